// ===== sv/gspe_pkg.sv =====
// Package: shared types and constants of the gas sensor ppm estimator.
package gspe_pkg;

	localparam int SAMPLES_DEF = 10;
	localparam int ADC_BITS_DEF = 12;
	localparam int CODE_W = 12;
	localparam int SUM_W = 24;
	localparam int PPM_W = 14;
	localparam logic [13:0] PPM_MAX = 14'd10000;
	localparam logic [31:0] INV_SLOPE_Q16 = 32'd139438;
	localparam logic [23:0] CURVE_C_Q16 = 24'd597995;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_LOW = 2'd2;
	localparam logic [2:0] LVL_FAULT = 3'd4;

	localparam logic [2:0] REG_MIN_CODE = 3'd0;
	localparam logic [2:0] REG_LOAD_RES = 3'd1;
	localparam logic [2:0] REG_RO = 3'd2;
	localparam logic [2:0] REG_RS_LIMIT = 3'd3;
	localparam logic [2:0] REG_LVL_ONE = 3'd4;
	localparam logic [2:0] REG_LVL_TWO = 3'd5;
	localparam logic [2:0] REG_LVL_THREE = 3'd6;

	typedef struct packed {
		logic [11:0] adc_code;
		logic        conversion_timed_out;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [13:0] gas_ppm;
		logic [2:0]  alert_level;
	} out_word_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [17:0] data;
	} cfg_word_t;

	function automatic logic [24:0] exp2_entry(input logic [3:0] i);
		logic [24:0] v;
		begin
			case (i)
				4'd0: v = 25'd23726566;
				4'd1: v = 25'd19951585;
				4'd2: v = 25'd18295684;
				4'd3: v = 25'd17520007;
				4'd4: v = 25'd17144589;
				4'd5: v = 25'd16959908;
				4'd6: v = 25'd16868315;
				4'd7: v = 25'd16822704;
				4'd8: v = 25'd16799944;
				4'd9: v = 25'd16788576;
				4'd10: v = 25'd16782895;
				4'd11: v = 25'd16780055;
				default: v = 25'd16777216;
			endcase
			return v;
		end
	endfunction

endpackage

// ===== sv/gspe_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module gspe_divider #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] q_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q, q_q[NUM_W-1]};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff[DEN_W-1:0];
				q_q <= {q_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				q_q <= {q_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
endmodule

// ===== sv/gspe_mult.sv =====
// Shift-add multiplier, one multiplier bit per cycle.
module gspe_mult #(
	parameter int A_W = 32,
	parameter int B_W = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               done,
	output logic [A_W+B_W-1:0] prod
);
	localparam int CNT_W = $clog2(B_W + 1);

	logic [A_W+B_W-1:0] acc_q;
	logic [A_W+B_W-1:0] a_q;
	logic [B_W-1:0]     b_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(B_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q <= {{B_W{1'b0}}, a};
			b_q <= b;
		end else if (busy_q) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign prod = acc_q;
endmodule

// ===== sv/gas_sensor_ppm_estimator_top.sv =====
// Top level of the gas sensor ppm estimator: burst averaging and power-law curve.
// Each input word is one ADC conversion. A timeout or a code below min_code
// aborts the burst at once and emits a fault word (ppm 0, alert 4). A fault
// word passes through S_OUT and a rejected code through S_ACC before the
// input is freed again. Otherwise Rs = RL*(FULL-code)/code is found by a
// shift-add multiplier followed by a bit-serial divider, and the sample holds
// the input while both run. After SAMPLES samples the sum is divided by
// SAMPLES. Then log2 of the average and of Ro is taken by repeated squaring
// (16 serial multiplies per operand). The log difference is scaled by 1/0.47
// (one serial multiply). Last, 2^frac is built from a 12-entry table (up to
// 12 serial multiplies). Every multiply goes through one shared 32-bit
// shift-add multiplier, which sets most of the latency. The output register
// holds the result while the next word is accepted; while a result word
// waits under stall, no new word is accepted.
module gas_sensor_ppm_estimator_top #(
	parameter int SAMPLES = gspe_pkg::SAMPLES_DEF,
	parameter int ADC_BITS = gspe_pkg::ADC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  gspe_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output gspe_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  gspe_pkg::cfg_word_t cfg_data
);
	import gspe_pkg::*;

	localparam logic [31:0] FULL = 32'((64'd1 << ADC_BITS) - 1);
	localparam int CNT_W = 7;

	typedef enum logic [4:0] {
		S_IDLE, S_RS_MUL, S_RS_DIV, S_ACC, S_AVG, S_LOG_NORM, S_LOG_SQ,
		S_LOG_NEXT, S_SCALE, S_EXP, S_EXP_MUL, S_FINISH, S_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [11:0] min_code_q;
	logic [15:0] load_res_q;
	logic [15:0] ro_q;
	logic [17:0] rs_limit_q;
	logic [13:0] lvl1_q, lvl2_q, lvl3_q;

	logic [SUM_W-1:0] rs_sum_q;
	logic [CNT_W-1:0] count_q;
	logic [11:0]      code_q;

	// log state
	logic        log_pass_q;       // 0: average, 1: Ro
	logic [31:0] l_avg_q;          // Q16 log2 of average
	logic [31:0] log_res_q;
	logic [15:0] mant_q;
	logic [3:0]  bit_q;
	logic [23:0] avg_q;

	// exp state
	logic [23:0] e_q;
	logic [24:0] emant_q;
	logic [3:0]  ebit_q;

	out_word_t out_q;
	logic      out_valid_q;

	// shared serial units
	logic        mul_start, mul_done;
	logic        mul_go, mul_go_q;
	logic        mul_start_all;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic        div_start, div_done;
	logic [31:0] div_num;
	logic [23:0] div_den;
	logic [31:0] div_q;

	gspe_mult #(.A_W(32), .B_W(32)) u_mult (
		.clk(clk), .arst_n(arst_n), .start(mul_start_all), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_p)
	);

	gspe_divider #(.NUM_W(32), .DEN_W(24)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quot(div_q)
	);

	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// leading-one position of a 24-bit value
	logic [4:0] lead;
	logic [23:0] log_x;
	assign log_x = log_pass_q ? {8'd0, ro_q} : avg_q;
	always_comb begin
		lead = '0;
		for (int i = 0; i < 24; i++) if (log_x[i]) lead = 5'(i);
	end

	logic [31:0] l_diff;
	logic [31:0] l_abs;
	assign l_diff = l_avg_q - log_res_q;
	assign l_abs = l_diff[31] ? (32'd0 - l_diff) : l_diff;

	logic [31:0] t_val;
	logic [24:0] e_full;
	logic [14:0] ppm_c;
	assign t_val = mul_p[47:16];
	assign e_full = l_diff[31] ? (25'(CURVE_C_Q16) + 25'(t_val))
		: (25'(CURVE_C_Q16) - 25'(t_val));

	logic [24:0] sh_mant;
	assign sh_mant = emant_q >> (5'd24 - {1'b0, e_q[19:16]});
	assign ppm_c = (sh_mant > 25'(PPM_MAX)) ? 15'(PPM_MAX) : 15'(sh_mant);

	function automatic logic [2:0] classify(input logic [13:0] p,
		input logic [13:0] a, input logic [13:0] b, input logic [13:0] c);
		logic [2:0] r;
		begin
			if (p < a) r = 3'd0;
			else if (p < b) r = 3'd1;
			else if (p < c) r = 3'd2;
			else r = 3'd3;
			return r;
		end
	endfunction

	always_comb begin
		mul_start = 1'b0;
		mul_a = '0;
		mul_b = '0;
		div_start = 1'b0;
		div_num = '0;
		div_den = '0;
		case (state_q)
			S_IDLE: begin
				mul_start = in_acc;
				mul_a = 32'(load_res_q);
				mul_b = FULL - 32'(in_data.adc_code);
			end
			S_RS_MUL: begin
				div_start = mul_done;
				div_num = mul_p[31:0];
				div_den = 24'(code_q);
			end
			S_AVG: begin
				div_start = 1'b0;
			end
			S_LOG_SQ: begin
				mul_a = 32'(mant_q);
				mul_b = 32'(mant_q);
			end
			S_SCALE: begin
				mul_a = l_abs;
				mul_b = INV_SLOPE_Q16;
			end
			S_EXP_MUL: begin
				mul_a = 32'(emant_q);
				mul_b = 32'(exp2_entry(ebit_q));
			end
			default: ;
		endcase
		if (state_q == S_ACC && count_q == CNT_W'(SAMPLES)) begin
			div_start = 1'b1;
			div_num = 32'(rs_sum_q);
			div_den = 24'(SAMPLES);
		end
		if (state_q == S_LOG_NEXT && bit_q != 4'd15 || state_q == S_LOG_NORM) begin
			mul_start = 1'b0;
		end
	end

	// sequencer issues of the shared multiplier: raised before a multiply state and
	// registered, so the start comes once the operand registers hold new values
	assign mul_go = (state_q == S_LOG_NORM)
		|| (state_q == S_LOG_NEXT && (bit_q != 4'd0 || log_pass_q))
		|| (state_q == S_EXP && e_q[23:16] < 8'd14 && ebit_q != 4'd12
			&& e_q[4'd15 - ebit_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mul_go_q <= 1'b0;
		else mul_go_q <= mul_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			rs_sum_q <= '0;
			count_q <= '0;
			min_code_q <= 12'd124;
			load_res_q <= 16'd2560;
			ro_q <= 16'd2560;
			rs_limit_q <= 18'd256000;
			lvl1_q <= 14'd200;
			lvl2_q <= 14'd800;
			lvl3_q <= 14'd2000;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_FINISH && state_q != S_OUT)
				out_valid_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_data.index)
					REG_MIN_CODE: min_code_q <= cfg_data.data[11:0];
					REG_LOAD_RES: load_res_q <= cfg_data.data[15:0];
					REG_RO: ro_q <= cfg_data.data[15:0];
					REG_RS_LIMIT: rs_limit_q <= cfg_data.data;
					REG_LVL_ONE: lvl1_q <= cfg_data.data[13:0];
					REG_LVL_TWO: lvl2_q <= cfg_data.data[13:0];
					REG_LVL_THREE: lvl3_q <= cfg_data.data[13:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						code_q <= in_data.adc_code;
						if (in_data.conversion_timed_out
							|| in_data.adc_code < min_code_q) begin
							rs_sum_q <= '0;
							count_q <= '0;
							out_q.status <= in_data.conversion_timed_out
								? ST_TIMEOUT : ST_LOW;
							out_q.gas_ppm <= '0;
							out_q.alert_level <= LVL_FAULT;
							state_q <= S_OUT;
						end else if (in_data.adc_code == 12'd0
							|| 32'(in_data.adc_code) >= FULL) begin
							count_q <= count_q + 1'b1;
							state_q <= S_ACC;
						end else begin
							state_q <= S_RS_MUL;
						end
					end
				end
				S_RS_MUL: if (mul_done) state_q <= S_RS_DIV;
				S_RS_DIV: begin
					if (div_done) begin
						if (div_q != 0 && div_q <= 32'(rs_limit_q)) begin
							rs_sum_q <= (25'(rs_sum_q) + 25'(div_q[23:0]) > 25'hFFFFFF
								|| div_q[31:24] != 0) ? 24'hFFFFFF
								: rs_sum_q + div_q[23:0];
						end
						count_q <= count_q + 1'b1;
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (count_q == CNT_W'(SAMPLES)) state_q <= S_AVG;
					else state_q <= S_IDLE;
				end
				S_AVG: begin
					if (div_done) begin
						avg_q <= div_q[23:0];
						rs_sum_q <= '0;
						count_q <= '0;
						log_pass_q <= 1'b0;
						if (div_q[23:0] == 0 || ro_q == 0) begin
							e_q <= '0;
							emant_q <= '0;
							state_q <= S_FINISH;
						end else state_q <= S_LOG_NORM;
					end
				end
				S_LOG_NORM: begin
					log_res_q <= {11'd0, lead, 16'd0};
					mant_q <= (lead >= 5'd15) ? 16'(log_x >> (lead - 5'd15))
						: 16'(log_x << (5'd15 - lead));
					bit_q <= 4'd15;
					state_q <= S_LOG_SQ;
				end
				S_LOG_SQ: begin
					if (mul_done) begin
						if (mul_p[31:15] >= 17'h10000) begin
							mant_q <= mul_p[31:16];
							log_res_q <= log_res_q | (32'd1 << bit_q);
						end else mant_q <= mul_p[30:15];
						state_q <= S_LOG_NEXT;
					end
				end
				S_LOG_NEXT: begin
					if (bit_q != 4'd0) begin
						bit_q <= bit_q - 1'b1;
						state_q <= S_LOG_SQ;
					end else if (!log_pass_q) begin
						l_avg_q <= log_res_q;
						log_pass_q <= 1'b1;
						state_q <= S_LOG_NORM;
					end else begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					if (mul_done) begin
						ebit_q <= 4'd0;
						if (e_full[24]) begin
							e_q <= '0;
							emant_q <= '0;
							state_q <= S_FINISH;
						end else begin
							e_q <= e_full[23:0];
							emant_q <= 25'd16777216;
							state_q <= S_EXP;
						end
					end
				end
				S_EXP: begin
					if (e_q[23:16] >= 8'd14) begin
						state_q <= S_FINISH;
					end else if (ebit_q == 4'd12) begin
						state_q <= S_FINISH;
					end else if (e_q[4'd15 - ebit_q]) begin
						state_q <= S_EXP_MUL;
					end else ebit_q <= ebit_q + 1'b1;
				end
				S_EXP_MUL: begin
					if (mul_done) begin
						emant_q <= mul_p[48:24];
						ebit_q <= ebit_q + 1'b1;
						state_q <= S_EXP;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						logic [13:0] p;
						p = (e_q[23:16] >= 8'd14) ? PPM_MAX
							: (emant_q == 0 ? 14'd0 : ppm_c[13:0]);
						out_q.status <= ST_OK;
						out_q.gas_ppm <= p;
						out_q.alert_level <= classify(p, lvl1_q, lvl2_q, lvl3_q);
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// the multiplier start for the serial log/scale/exp steps goes through mul_go_q
	// so that operand registers have settled; it is folded in here
	assign mul_start_all = mul_start || mul_go_q;

`ifndef ASSERT_OFF
	a_no_out_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && $past(state_q) == S_IDLE && !$past(in_acc))
		|-> !$rose(out_valid)) else $error("result without an accepted word");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SAMPLES)) else $error("sample count past burst length");
	a_fault_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.alert_level == LVL_FAULT
		&& out_data.gas_ppm == 14'd0) else $error("fault word malformed");
`endif
endmodule

// ===== tb/sv/gspe_checker.sv =====
// Checker: watches the config, input and output channels, predicts ppm words, compares.
module gspe_checker #(
	parameter int SAMPLES = gspe_pkg::SAMPLES_DEF,
	parameter int ADC_BITS = gspe_pkg::ADC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  gspe_pkg::in_word_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  gspe_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  gspe_pkg::cfg_word_t cfg_data,
	output int                  fails,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import gspe_pkg::*;

	localparam longint unsigned FULL = (64'd1 << ADC_BITS) - 1;
	localparam longint unsigned SUM_SAT = 64'hFFFFFF;

	// 2^(2^-i) in Q24, i = 1..12
	localparam longint unsigned POW_FRAC [12] = '{
		23726566, 19951585, 18295684, 17520007, 17144589, 16959908,
		16868315, 16822704, 16799944, 16788576, 16782895, 16780055
	};

	logic [11:0] min_code;
	logic [15:0] load_res, ro;
	logic [17:0] rs_limit;
	logic [13:0] lvl_one, lvl_two, lvl_three;
	logic [23:0] rs_sum;
	logic [6:0]  n_taken;
	out_word_t   ppm_q[$];

	// log2 in Q16 by repeated squaring of a Q15 mantissa
	function automatic longint log2_fix(input longint unsigned x);
		int n;
		longint unsigned m;
		longint r;
		n = 0;
		while (n < 63 && (x >> (n + 1)) != 0) n++;
		m = (n >= 15) ? (x >> (n - 15)) : (x << (15 - n));
		r = longint'(n) * 65536;
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 15;
			if (m >= 64'd65536) begin
				m = m >> 1;
				r += longint'(1) << i;
			end
		end
		return r;
	endfunction

	function automatic logic [13:0] ppm_of(input longint unsigned avg,
			input longint unsigned ro_v);
		longint l, t, e;
		longint unsigned mant, n, f;
		if (avg == 0 || ro_v == 0) return '0;
		l = log2_fix(avg) - log2_fix(ro_v);
		if (l >= 0) t = longint'((longint'(l) * longint'(INV_SLOPE_Q16)) >>> 16);
		else t = -longint'(((-l) * longint'(INV_SLOPE_Q16)) >>> 16);
		e = longint'(CURVE_C_Q16) - t;
		if (e < 0) return '0;
		n = e >> 16;
		if (n >= 14) return PPM_MAX;
		f = (e >> 4) & 64'hFFF;
		mant = 64'd1 << 24;
		for (int i = 0; i < 12; i++)
			if ((f >> (11 - i)) & 1) mant = (mant * POW_FRAC[i]) >> 24;
		mant = mant >> (24 - n);
		return (mant > PPM_MAX) ? PPM_MAX : mant[13:0];
	endfunction

	function automatic logic [2:0] level_of(input logic [13:0] p);
		if (p < lvl_one) return 3'd0;
		if (p < lvl_two) return 3'd1;
		if (p < lvl_three) return 3'd2;
		return 3'd3;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		longint unsigned rs, s;
		out_word_t w, e;
		if (!arst_n) begin
			min_code = 12'd124;
			load_res = 16'd2560;
			ro = 16'd2560;
			rs_limit = 18'd256000;
			lvl_one = 14'd200;
			lvl_two = 14'd800;
			lvl_three = 14'd2000;
			rs_sum = '0;
			n_taken = '0;
			fails = 0;
			pending = 0;
			ppm_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (ppm_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected word %p", $time, out_data);
				end else begin
					e = ppm_q.pop_front();
					if (out_data.status !== e.status)
						$display("%0t: status exp %0d got %0d", $time, e.status, out_data.status);
					if (out_data.gas_ppm !== e.gas_ppm)
						$display("%0t: ppm exp %0d got %0d", $time, e.gas_ppm, out_data.gas_ppm);
					if (out_data.alert_level !== e.alert_level)
						$display("%0t: alert exp %0d got %0d", $time, e.alert_level,
							out_data.alert_level);
					if (out_data !== e) fails++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.index)
					REG_MIN_CODE:  min_code = cfg_data.data[11:0];
					REG_LOAD_RES:  load_res = cfg_data.data[15:0];
					REG_RO:        ro = cfg_data.data[15:0];
					REG_RS_LIMIT:  rs_limit = cfg_data.data;
					REG_LVL_ONE:   lvl_one = cfg_data.data[13:0];
					REG_LVL_TWO:   lvl_two = cfg_data.data[13:0];
					REG_LVL_THREE: lvl_three = cfg_data.data[13:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (in_data.conversion_timed_out || in_data.adc_code < min_code) begin
					rs_sum = '0;
					n_taken = '0;
					w.status = in_data.conversion_timed_out ? ST_TIMEOUT : ST_LOW;
					w.gas_ppm = '0;
					w.alert_level = LVL_FAULT;
					ppm_q.push_back(w);
				end else begin
					if (in_data.adc_code != 0 && in_data.adc_code < FULL) begin
						rs = (longint'(load_res) * (FULL - in_data.adc_code)) / in_data.adc_code;
						if (rs > 0 && rs <= rs_limit) begin
							s = rs_sum + rs;
							rs_sum = (s > SUM_SAT) ? 24'hFFFFFF : s[23:0];
						end
					end
					n_taken = n_taken + 7'd1;
					if (n_taken >= SAMPLES) begin
						w.status = ST_OK;
						w.gas_ppm = ppm_of(rs_sum / SAMPLES, ro);
						w.alert_level = level_of(w.gas_ppm);
						ppm_q.push_back(w);
						rs_sum = '0;
						n_taken = '0;
					end
				end
			end
			pending = ppm_q.size();
		end
	end
endmodule

// ===== tb/sv/tb_gas_sensor_ppm_estimator_top.sv =====
// Testbench top: drives configs and ADC words at random pace, gives the verdict.
module tb_gas_sensor_ppm_estimator_top;
	timeunit 1ns;
	timeprecision 1ps;
	import gspe_pkg::*;

	localparam int PHASES = 8;
	localparam int PER_PHASE = 120;
	localparam int SETTLE = 300;
	localparam int WATCHDOG = 20000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	cfg_word_t cfg_data = '0;
	int        fails, pending;
	int        n_words = 0, n_results = 0, idle_cycles = 0, stall_left = 0;
	bit        quiet = 1'b0;      // no idling on either side
	logic [11:0] cur_min = 12'd124;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	gas_sensor_ppm_estimator_top dut (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data, .cfg_valid, .cfg_ready, .cfg_data
	);

	gspe_checker chk (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data, .cfg_valid, .cfg_ready, .cfg_data,
		.fails, .pending
	);

	// Result side: random stall per word, counted down every cycle.
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			n_results++;
			stall_left = quiet ? 0 : $urandom_range(0, 6);
		end else if (stall_left > 0)
			stall_left--;
		out_stall <= (stall_left != 0);
	end

	// Watchdog: cycles with no word accepted on any channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else if (++idle_cycles >= WATCHDOG) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic cfg_write(input logic [2:0] idx, input logic [17:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= '{index: idx, data: val};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_MIN_CODE) cur_min = val[11:0];
	endtask

	// One ADC word; valid stays high across back-to-back words.
	task automatic send(input logic [11:0] code, input bit to);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{adc_code: code, conversion_timed_out: to};
		do @(posedge clk); while (in_stall);
		n_words++;
	endtask

	task automatic drain();
		if (in_valid) begin
			@(posedge clk);
			in_valid <= 1'b0;
		end
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_all(input logic [11:0] mc, input logic [15:0] rl,
			input logic [15:0] r0, input logic [17:0] lim,
			input logic [13:0] a, input logic [13:0] b, input logic [13:0] c);
		cfg_write(REG_MIN_CODE, 18'(mc));
		cfg_write(REG_LOAD_RES, 18'(rl));
		cfg_write(REG_RO, 18'(r0));
		cfg_write(REG_RS_LIMIT, lim);
		cfg_write(REG_LVL_ONE, 18'(a));
		cfg_write(REG_LVL_TWO, 18'(b));
		cfg_write(REG_LVL_THREE, 18'(c));
	endtask

	// Mostly well-formed samples; a few timeouts and low-voltage codes.
	task automatic random_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			send(12'($urandom), 1'b1);
		else if (r < 6 && cur_min > 0)
			send(12'($urandom_range(0, cur_min - 1)), 1'b0);
		else if (r < 40)
			send(12'($urandom_range(cur_min, 4095)), 1'b0);
		else
			send(12'($urandom_range(cur_min > 1500 ? cur_min : 1500, 4095)), 1'b0);
	endtask

	initial begin
		logic [13:0] t1, t2, t3;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed at reset settings: fault words, rejected codes, full bursts.
		send(12'd4095, 1'b1);   // timeout beats everything
		send(12'd0, 1'b0);      // below min_code
		send(12'd123, 1'b0);
		send(12'd124, 1'b0); send(12'd4095, 1'b0); send(12'd4094, 1'b0);
		send(12'd2048, 1'b0); send(12'd1000, 1'b0); send(12'd3000, 1'b0);
		send(12'd500, 1'b0); send(12'd200, 1'b0); send(12'd3500, 1'b0);
		send(12'd4000, 1'b0);
		send(12'd2000, 1'b0); send(12'd2500, 1'b0);
		send(12'd1234, 1'b1);   // timeout mid-burst clears it
		for (int i = 0; i < 10; i++) send(12'd4095, 1'b0);  // all rejected: zero average
		drain();

		for (int p = 0; p < PHASES; p++) begin
			quiet = (p % 3 == 1);
			case (p)
				0: cfg_all(12'd0, 16'd1, 16'd1, 18'd0, 14'd0, 14'd0, 14'd0);
				1: cfg_all(12'd4095, 16'hFFFF, 16'hFFFF, 18'h3FFFF,
					14'd10000, 14'd10000, 14'd10000);
				2: cfg_all(12'd0, 16'd2560, 16'd0, 18'h3FFFF, 14'd1, 14'd2, 14'd3);
				3: cfg_all(12'd0, 16'hFFFF, 16'd1, 18'h3FFFF, 14'd100, 14'd1000, 14'd9999);
				default: begin
					t1 = 14'($urandom_range(0, 10000));
					t2 = 14'($urandom_range(0, 10000));
					t3 = 14'($urandom_range(0, 10000));
					cfg_all(12'($urandom_range(0, 300)), 16'($urandom_range(1, 65535)),
						16'($urandom_range(1, 65535)), 18'($urandom_range(0, 262143)),
						t1, t2, t3);
				end
			endcase
			if (p == 0) begin
				// Code zero allowed by min_code: infinite Rs, rejected.
				for (int i = 0; i < 10; i++) send(i % 2 ? 12'd0 : 12'd1, 1'b0);
			end
			for (int i = 0; i < PER_PHASE; i++) random_word();
			drain();
		end

		$display("Sent %0d ADC words over %0d config phases, checked %0d result words.",
			n_words, PHASES + 1, n_results);
		$display("Covered timeouts, low-voltage aborts, rejected samples and extreme registers.");
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/gspe_pkg.sv
sv/gspe_divider.sv
sv/gspe_mult.sv
sv/gas_sensor_ppm_estimator_top.sv
tb/sv/gspe_checker.sv
tb/sv/tb_gas_sensor_ppm_estimator_top.sv
